// ===== rtl/i2c_master_transaction_sequencer_core_assert.svh =====
// Assertion macros shared by the I2C transaction sequencer modules.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define I2CMTS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define I2CMTS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define I2CMTS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define I2CMTS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/i2cmts_pkg.sv =====
// Types, codes and constants of the I2C master transaction sequencer.
package i2cmts_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;

    // Direction bit appended to the slave address for a read.
    localparam logic RD_BIT = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_EVENT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_ZERO     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_SEND    = 3'd2,
        CMD_RESTART = 3'd3,
        CMD_STOP    = 3'd4,
        CMD_RECEIVE = 3'd5,
        CMD_ACK     = 3'd6,
        CMD_NACK    = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        CMP_NONE    = 3'd0,
        CMP_WR_DONE = 3'd1,
        CMP_RD_DONE = 3'd2,
        CMP_WR_FAIL = 3'd3,
        CMP_RD_FAIL = 3'd4
    } t_comp;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_ADDR_W  = 4'd2,
        PH_DATA    = 4'd3,
        PH_RESTART = 4'd4,
        PH_ADDR_R  = 4'd5,
        PH_WAIT_RX = 4'd6,
        PH_ACK     = 4'd7,
        PH_NACK    = 4'd8,
        PH_STOP    = 4'd9,
        PH_ERROR   = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        CTL_IDLE  = 2'd0,
        CTL_EXEC  = 2'd1,
        CTL_DRAIN = 2'd2
    } t_ctl;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] slave_address;
        logic [7:0] register_address;
        logic [7:0] length;
        logic [4:0] load_index;
        logic [7:0] load_byte;
        logic       ack_status;
        logic [7:0] received_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] request_status;
        logic [2:0] bus_command;
        logic [7:0] transmit_byte;
        logic [2:0] completion;
        logic [5:0] received_count;
        logic [7:0] read_data;
        logic       last;
        logic       unexpected_event;
    } t_out;

    // Control from the sequencer to the buffer and output logic.
    typedef struct packed {
        logic emit;
        logic drain;
        logic load_wr;
        logic rx_wr;
        logic fetch_next;
    } t_seq_ctl;

endpackage

// ===== rtl/i2cmts_seq.sv =====
// Transaction state and per-step bus command generation.
`include "i2c_master_transaction_sequencer_core_assert.svh"

module i2cmts_seq #(
    parameter int BUFFER_DEPTH = i2cmts_pkg::BUFFER_DEPTH_DEF,
    localparam int PW = $clog2(BUFFER_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ignore_nack,
    input  i2cmts_pkg::t_in       i_item,
    input  logic                  i_step,
    input  logic [7:0]            i_rdata,
    output i2cmts_pkg::t_out      o_res,
    output i2cmts_pkg::t_seq_ctl  o_ctl,
    output logic [PW-1:0]         o_pos
);

    i2cmts_pkg::t_mode   r_mode, n_mode;
    i2cmts_pkg::t_phase  r_phase, n_phase;
    logic [PW-1:0]       r_len, n_len;
    logic [PW-1:0]       r_pos, n_pos;
    logic [6:0]          r_addr, n_addr;
    logic [7:0]          r_reg, n_reg;

    logic                w_nack;
    logic [PW-1:0]       w_pos_inc;
    logic                w_more;
    logic                w_writing;
    i2cmts_pkg::t_status w_status;

    assign w_nack    = i_item.ack_status & ~i_ignore_nack;
    assign w_pos_inc = r_pos + PW'(1);
    assign w_more    = (w_pos_inc < r_len);
    assign w_writing = (r_mode == i2cmts_pkg::MODE_WRITE);
    assign o_pos     = r_pos;

    always_comb begin
        if (r_mode != i2cmts_pkg::MODE_IDLE) begin
            w_status = i2cmts_pkg::ST_BUSY;
        end else if (i_item.length > 8'(BUFFER_DEPTH)) begin
            w_status = i2cmts_pkg::ST_TOO_LONG;
        end else if (i_item.length == 8'd0) begin
            w_status = i2cmts_pkg::ST_ZERO;
        end else begin
            w_status = i2cmts_pkg::ST_OK;
        end
    end

    // Next transaction state, taken only when the top level commits a step.
    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_len   = r_len;
        n_pos   = r_pos;
        n_addr  = r_addr;
        n_reg   = r_reg;
        case (i_item.kind)
            i2cmts_pkg::KIND_WRITE, i2cmts_pkg::KIND_READ: begin
                if (w_status == i2cmts_pkg::ST_OK) begin
                    n_mode  = (i_item.kind == i2cmts_pkg::KIND_READ) ?
                              i2cmts_pkg::MODE_READ : i2cmts_pkg::MODE_WRITE;
                    n_len   = PW'(i_item.length);
                    n_pos   = '0;
                    n_addr  = i_item.slave_address;
                    n_phase = i2cmts_pkg::PH_START;
                    if (i_item.kind == i2cmts_pkg::KIND_READ) begin
                        n_reg = i_item.register_address;
                    end
                end
            end
            i2cmts_pkg::KIND_EVENT: begin
                if (r_mode == i2cmts_pkg::MODE_IDLE) begin
                    n_phase = i2cmts_pkg::PH_IDLE;
                end else begin
                    case (r_phase)
                        i2cmts_pkg::PH_START: n_phase = i2cmts_pkg::PH_ADDR_W;
                        i2cmts_pkg::PH_ADDR_W: begin
                            n_phase = w_nack ? i2cmts_pkg::PH_ERROR : i2cmts_pkg::PH_DATA;
                        end
                        i2cmts_pkg::PH_DATA: begin
                            if (w_nack) begin
                                n_phase = i2cmts_pkg::PH_ERROR;
                            end else if (w_writing) begin
                                n_pos = w_pos_inc;
                                if (!w_more) begin
                                    n_phase = i2cmts_pkg::PH_STOP;
                                end
                            end else begin
                                n_phase = i2cmts_pkg::PH_RESTART;
                            end
                        end
                        i2cmts_pkg::PH_RESTART: n_phase = i2cmts_pkg::PH_ADDR_R;
                        i2cmts_pkg::PH_ADDR_R: begin
                            n_phase = w_nack ? i2cmts_pkg::PH_ERROR : i2cmts_pkg::PH_WAIT_RX;
                        end
                        i2cmts_pkg::PH_WAIT_RX: begin
                            n_pos   = w_pos_inc;
                            n_phase = w_more ? i2cmts_pkg::PH_ACK : i2cmts_pkg::PH_NACK;
                        end
                        i2cmts_pkg::PH_ACK:  n_phase = i2cmts_pkg::PH_WAIT_RX;
                        i2cmts_pkg::PH_NACK: n_phase = i2cmts_pkg::PH_STOP;
                        i2cmts_pkg::PH_STOP, i2cmts_pkg::PH_ERROR: begin
                            n_mode  = i2cmts_pkg::MODE_IDLE;
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end
                        default: n_phase = i2cmts_pkg::PH_ERROR;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Result and buffer control for the current item.
    always_comb begin
        o_res            = '0;
        o_res.last       = 1'b1;
        o_ctl            = '0;
        o_ctl.emit       = 1'b1;
        o_ctl.fetch_next = (r_phase == i2cmts_pkg::PH_DATA);
        case (i_item.kind)
            i2cmts_pkg::KIND_LOAD: begin
                o_ctl.emit    = 1'b0;
                o_ctl.load_wr = (r_mode == i2cmts_pkg::MODE_IDLE);
            end
            i2cmts_pkg::KIND_WRITE, i2cmts_pkg::KIND_READ: begin
                o_res.request_status = w_status;
                o_res.bus_command    = (w_status == i2cmts_pkg::ST_OK) ?
                                       i2cmts_pkg::CMD_START : i2cmts_pkg::CMD_NONE;
            end
            default: begin
                if (r_mode == i2cmts_pkg::MODE_IDLE) begin
                    o_res.unexpected_event = (r_phase != i2cmts_pkg::PH_ERROR);
                end else begin
                    case (r_phase)
                        i2cmts_pkg::PH_START: begin
                            o_res.bus_command   = i2cmts_pkg::CMD_SEND;
                            o_res.transmit_byte = {r_addr, 1'b0};
                        end
                        i2cmts_pkg::PH_ADDR_W: begin
                            if (w_nack) begin
                                o_res.bus_command = i2cmts_pkg::CMD_STOP;
                            end else begin
                                o_res.bus_command   = i2cmts_pkg::CMD_SEND;
                                o_res.transmit_byte = w_writing ? i_rdata : r_reg;
                            end
                        end
                        i2cmts_pkg::PH_DATA: begin
                            if (w_nack) begin
                                o_res.bus_command = i2cmts_pkg::CMD_STOP;
                            end else if (w_writing) begin
                                if (w_more) begin
                                    o_res.bus_command   = i2cmts_pkg::CMD_SEND;
                                    o_res.transmit_byte = i_rdata;
                                end else begin
                                    o_res.bus_command = i2cmts_pkg::CMD_STOP;
                                end
                            end else begin
                                o_res.bus_command = i2cmts_pkg::CMD_RESTART;
                            end
                        end
                        i2cmts_pkg::PH_RESTART: begin
                            o_res.bus_command   = i2cmts_pkg::CMD_SEND;
                            o_res.transmit_byte = {r_addr, i2cmts_pkg::RD_BIT};
                        end
                        i2cmts_pkg::PH_ADDR_R: begin
                            o_res.bus_command = w_nack ? i2cmts_pkg::CMD_STOP :
                                                i2cmts_pkg::CMD_RECEIVE;
                        end
                        i2cmts_pkg::PH_WAIT_RX: begin
                            o_ctl.rx_wr       = 1'b1;
                            o_res.bus_command = w_more ? i2cmts_pkg::CMD_ACK :
                                                i2cmts_pkg::CMD_NACK;
                        end
                        i2cmts_pkg::PH_ACK:  o_res.bus_command = i2cmts_pkg::CMD_RECEIVE;
                        i2cmts_pkg::PH_NACK: o_res.bus_command = i2cmts_pkg::CMD_STOP;
                        i2cmts_pkg::PH_STOP, i2cmts_pkg::PH_ERROR: begin
                            if (r_mode == i2cmts_pkg::MODE_READ &&
                                r_phase == i2cmts_pkg::PH_STOP) begin
                                // A successful read hands the buffer to the read-out.
                                if (r_pos == '0) begin
                                    o_res.completion = i2cmts_pkg::CMP_RD_DONE;
                                end else begin
                                    o_ctl.drain = 1'b1;
                                    o_ctl.emit  = 1'b0;
                                end
                            end else if (w_writing) begin
                                o_res.completion = (r_phase == i2cmts_pkg::PH_ERROR) ?
                                    i2cmts_pkg::CMP_WR_FAIL : i2cmts_pkg::CMP_WR_DONE;
                            end else begin
                                o_res.completion = (r_phase == i2cmts_pkg::PH_ERROR) ?
                                    i2cmts_pkg::CMP_RD_FAIL : i2cmts_pkg::CMP_RD_DONE;
                            end
                        end
                        default: o_res.bus_command = i2cmts_pkg::CMD_STOP;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= i2cmts_pkg::MODE_IDLE;
            r_phase <= i2cmts_pkg::PH_IDLE;
            r_len   <= '0;
            r_pos   <= '0;
            r_addr  <= '0;
            r_reg   <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_addr  <= n_addr;
            r_reg   <= n_reg;
        end
    end

    `I2CMTS_ASSERT_IMP(a_idle_phase, i_clk, i_rst_n, r_mode == i2cmts_pkg::MODE_IDLE, r_phase == i2cmts_pkg::PH_IDLE, "phase active without a transaction")
    `I2CMTS_ASSERT_IMP(a_pos_in_len, i_clk, i_rst_n, 1'b1, r_pos <= r_len, "byte position past transfer length")
    `I2CMTS_ASSERT_IMP(a_drain_read, i_clk, i_rst_n, o_ctl.drain, r_mode == i2cmts_pkg::MODE_READ, "read-out requested outside a read")

endmodule

// ===== rtl/i2c_master_transaction_sequencer_core.sv =====
// Top level of the I2C master transaction sequencer with the byte buffer memory.
//
//  Channel  Direction  Handshake       Payload
//  cfg      in         valid / ready   ignore_nack (1 bit)
//  in       in         valid / stall   i2cmts_pkg::t_in
//  out      out        valid / stall   i2cmts_pkg::t_out
//
// An item is executed in the cycle after it is taken when the output register is free;
// execution waits while an earlier result is stalled. The buffer is a single memory
// with a registered read; the byte for a send is fetched in the cycle the item is taken,
// and a read completion emits its n bytes at one per cycle while the output is not stalled.
// Reset is synchronous and clears control state only; the buffer is not cleared.
`include "i2c_master_transaction_sequencer_core_assert.svh"

module i2c_master_transaction_sequencer_core #(
    parameter int BUFFER_DEPTH = i2cmts_pkg::BUFFER_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  i2cmts_pkg::t_in   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output i2cmts_pkg::t_out  o_out_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int PW = $clog2(BUFFER_DEPTH + 1);

    i2cmts_pkg::t_ctl     r_ctl, n_ctl;
    i2cmts_pkg::t_in      r_item;
    logic                 r_ignore_nack;
    logic [7:0]           r_mem [BUFFER_DEPTH];
    logic [7:0]           r_rdata;
    logic                 r_ovalid;
    i2cmts_pkg::t_out     r_out;
    logic [PW-1:0]        r_didx;
    logic [PW-1:0]        r_dcount;

    i2cmts_pkg::t_out     w_res;
    i2cmts_pkg::t_seq_ctl w_ctl;
    logic [PW-1:0]        w_pos;
    logic [PW-1:0]        w_fetch;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_exec_go;
    logic                 w_drain_load;
    logic                 w_drain_last;
    logic [AW-1:0]        w_raddr;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [7:0]           w_wdata;

    i2cmts_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ignore_nack (r_ignore_nack),
        .i_item        (r_item),
        .i_step        (w_exec_go),
        .i_rdata       (r_rdata),
        .o_res         (w_res),
        .o_ctl         (w_ctl),
        .o_pos         (w_pos)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_ovalid;
    assign o_out_data   = r_out;

    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_ovalid || !i_out_stall;
    assign w_exec_go    = (r_ctl == i2cmts_pkg::CTL_EXEC) && (!w_ctl.emit || w_out_free);
    assign w_drain_load = (r_ctl == i2cmts_pkg::CTL_DRAIN) && w_out_free;
    assign w_drain_last = (r_didx + PW'(1) == r_dcount);
    assign w_fetch      = w_ctl.fetch_next ? w_pos + PW'(1) : w_pos;

    always_comb begin
        n_ctl = r_ctl;
        case (r_ctl)
            i2cmts_pkg::CTL_IDLE: begin
                if (w_accept) begin
                    n_ctl = i2cmts_pkg::CTL_EXEC;
                end
            end
            i2cmts_pkg::CTL_EXEC: begin
                if (w_exec_go) begin
                    n_ctl = w_ctl.drain ? i2cmts_pkg::CTL_DRAIN : i2cmts_pkg::CTL_IDLE;
                end
            end
            i2cmts_pkg::CTL_DRAIN: begin
                if (w_drain_load && w_drain_last) begin
                    n_ctl = i2cmts_pkg::CTL_IDLE;
                end
            end
            default: n_ctl = i2cmts_pkg::CTL_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_ctl != i2cmts_pkg::CTL_IDLE);
        case (r_ctl)
            i2cmts_pkg::CTL_DRAIN: begin
                // Run the read address one byte ahead whenever the output moves.
                w_raddr = w_drain_load ? AW'(r_didx + PW'(1)) : AW'(r_didx);
            end
            i2cmts_pkg::CTL_EXEC: begin
                w_raddr = (w_exec_go && w_ctl.drain) ? '0 : AW'(w_fetch);
            end
            default: w_raddr = AW'(w_fetch);
        endcase
        w_we    = w_exec_go &&
                  ((w_ctl.load_wr && (7'(r_item.load_index) < 7'(BUFFER_DEPTH))) ||
                   (w_ctl.rx_wr && (w_pos < PW'(BUFFER_DEPTH))));
        w_waddr = w_ctl.load_wr ? AW'(r_item.load_index) : AW'(w_pos);
        w_wdata = w_ctl.load_wr ? r_item.load_byte : r_item.received_byte;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl         <= i2cmts_pkg::CTL_IDLE;
            r_ignore_nack <= 1'b0;
            r_ovalid      <= 1'b0;
            r_didx        <= '0;
            r_dcount      <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ignore_nack <= i_cfg_data;
            end
            if ((w_exec_go && w_ctl.emit) || w_drain_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (w_exec_go && w_ctl.drain) begin
                r_didx   <= '0;
                r_dcount <= w_pos;
            end else if (w_drain_load) begin
                r_didx <= r_didx + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
        if (w_exec_go && w_ctl.emit) begin
            r_out <= w_res;
        end else if (w_drain_load) begin
            r_out <= '{i2cmts_pkg::ST_OK, i2cmts_pkg::CMD_NONE, 8'h00,
                       i2cmts_pkg::CMP_RD_DONE, 6'(r_dcount), r_rdata, w_drain_last, 1'b0};
        end
    end

    `I2CMTS_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, w_accept,
                       r_ctl == i2cmts_pkg::CTL_EXEC, "taken item not executed next cycle")
    `I2CMTS_ASSERT_IMP(a_drain_range, i_clk, i_rst_n, r_ctl == i2cmts_pkg::CTL_DRAIN,
                       r_didx < r_dcount, "read-out index past received count")
    `I2CMTS_ASSERT_NXT(a_exec_free, i_clk, i_rst_n,
                       r_ctl == i2cmts_pkg::CTL_EXEC && !r_ovalid,
                       r_ctl != i2cmts_pkg::CTL_EXEC, "execution held with a free output")

endmodule
